>>> rtl/tracker_reply_frame_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tracker reply frame decoder
// Implication and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef TRACKER_REPLY_FRAME_DECODER_UNIT_ASSERT_SVH
`define TRACKER_REPLY_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define TRFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trfd assertion failed (same cycle)");

// next-cycle implication
`define TRFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trfd assertion failed (next cycle)");

`endif

>>> rtl/trfd_pkg.sv
// ----------------------------------------------------------------------------
// trfd_pkg
// Types, constants and helpers for the tracker reply frame decoder.
// ----------------------------------------------------------------------------
package trfd_pkg;

   localparam int unsigned MAX_RECORD_BYTES = 4096;
   localparam int unsigned FRAME_BYTES      = 19;
   localparam int unsigned STORE_DEPTH      = FRAME_BYTES - 1;
   localparam int unsigned LEN_W            = 13;
   localparam int unsigned POS_W            = 5;

   // multiplicative inverse of the frame size mod 2**LEN_W; a multiple of the
   // frame size maps to its quotient, everything else lands above the limit
   localparam logic [LEN_W-1:0] INV_FRAME  = 13'd2587;
   localparam logic [LEN_W-1:0] MULT_LIMIT = LEN_W'((2**LEN_W - 1) / FRAME_BYTES);

   typedef enum logic [1:0] {
      KIND_UNKNOWN  = 2'd0,
      KIND_INIT     = 2'd1,
      KIND_MESSAGE  = 2'd2,
      KIND_DATA_SET = 2'd3
   } frame_kind_type;

   localparam logic [7:0] ACK_CODE    = 8'h06;
   localparam logic [7:0] TAG_MASK    = 8'hF0;
   localparam logic [7:0] DS_TAG      = 8'hE0;
   localparam logic [7:0] MARKER_FLAG = 8'h80;
   localparam logic [7:0] PRINT_FIRST = 8'h20;
   localparam logic [7:0] PRINT_LAST  = 8'h7E;
   localparam logic [7:0] INIT_B0     = 8'h01;
   localparam logic [7:0] INIT_B1     = 8'h02;
   localparam logic [7:0] INIT_B2     = 8'h03;
   localparam logic [7:0] INIT_B3     = 8'h04;

   function automatic logic printable(input logic [7:0] b);
      return b inside {[PRINT_FIRST:PRINT_LAST]};
   endfunction

   function automatic logic length_ok(input logic [LEN_W-1:0] len);
      logic [2*LEN_W-1:0] prod;
      prod = (2*LEN_W)'(len) * (2*LEN_W)'(INV_FRAME);
      return (len != '0) && (len <= LEN_W'(MAX_RECORD_BYTES)) &&
             (prod[LEN_W-1:0] <= MULT_LIMIT);
   endfunction

endpackage

>>> rtl/tracker_reply_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// tracker_reply_frame_decoder_unit
// Cuts a receive record into 19-byte frames, classifies and decodes each one.
// ----------------------------------------------------------------------------
//  channel | ports             | direction | moves
//  req_    | valid/ready       | in        | one record byte + start + length
//  rsp_    | valid/ready       | out       | one decoded frame (or unknown)
//
//  One byte per cycle while the result register is free or being drained; a
//  frame is decoded in the cycle its last byte is taken and its result shows
//  in the next cycle from the result register. A byte that yields no result is still taken.
//  Reset clears positions, length flag and the result valid; the frame byte
//  store has no reset. A stalled result holds the request side only when
//  the result register is full and not being drained.
module tracker_reply_frame_decoder_unit import trfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_rx_byte,
   input  logic                     req_record_start,
   input  logic [LEN_W-1:0]         req_record_length,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_frame_kind,
   output logic [63:0]              rsp_wide_word,
   output logic signed [23:0]       rsp_x_coord,
   output logic signed [23:0]       rsp_y_coord,
   output logic signed [23:0]       rsp_z_coord,
   output logic [31:0]              rsp_status_word,
   output logic [6:0]               rsp_marker_id,
   output logic [3:0]               rsp_module_id,
   output logic [5:0]               rsp_trigger_index,
   output logic [31:0]              rsp_message_info,
   output logic [31:0]              rsp_check_word,
   output logic                     rsp_record_end
);

   logic [7:0]       store_ff [STORE_DEPTH];
   logic [POS_W-1:0] frame_pos_ff, frame_pos_in;
   logic [LEN_W-1:0] rec_pos_ff, rec_pos_in;
   logic             len_bad_ff, len_bad_in;
   logic             store_we;

   logic             rsp_valid_ff;
   logic [1:0]       kind_ff, kind_in;
   logic [63:0]      wide_ff, wide_in;
   logic [23:0]      x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [31:0]      status_ff, status_in;
   logic [6:0]       marker_ff, marker_in;
   logic [3:0]       module_ff, module_in;
   logic [5:0]       trig_ff, trig_in;
   logic [31:0]      info_ff, info_in;
   logic [31:0]      check_ff, check_in;
   logic             end_ff, end_in;

   logic             accept, produce;
   logic [LEN_W-1:0] pos, pos_next;
   logic [POS_W-1:0] fpos;
   logic             bad, taken, last;
   logic [7:0]       p [FRAME_BYTES];
   logic             is_init, is_ds, is_msg;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         p[i] = store_ff[i];
      end
      p[STORE_DEPTH] = req_rx_byte;
   end

   // frame classification
   always_comb begin
      is_init = (p[0] == INIT_B0) && (p[1] == INIT_B1) &&
                (p[2] == INIT_B2) && (p[3] == INIT_B3);
      is_ds   = ((p[18] & TAG_MASK) == DS_TAG) && ((p[17] & MARKER_FLAG) == MARKER_FLAG);
      is_msg  = ((p[14] == ACK_CODE) && printable(p[0])) ||
                (!is_ds && printable(p[0]) && printable(p[1]));
   end

   // record tracking
   always_comb begin
      if (req_record_start) begin
         pos  = '0;
         fpos = '0;
         bad  = !length_ok(req_record_length);
      end else begin
         pos  = rec_pos_ff;
         fpos = frame_pos_ff;
         bad  = len_bad_ff;
      end
      pos_next     = LEN_W'(pos + LEN_W'(1));
      taken        = pos < req_record_length;
      last         = pos_next == req_record_length;
      rec_pos_in   = taken ? pos_next : pos;
      len_bad_in   = bad;
      frame_pos_in = fpos;
      store_we     = 1'b0;
      produce      = 1'b0;
      if (taken) begin
         if (bad) begin
            produce = last;
         end else if (fpos == POS_W'(STORE_DEPTH)) begin
            produce      = 1'b1;
            frame_pos_in = '0;
         end else begin
            store_we     = 1'b1;
            frame_pos_in = POS_W'(fpos + POS_W'(1));
         end
      end
   end

   // result fields
   always_comb begin
      kind_in   = KIND_UNKNOWN;
      wide_in   = '0;
      x_in      = '0;
      y_in      = '0;
      z_in      = '0;
      status_in = '0;
      marker_in = '0;
      module_in = '0;
      trig_in   = '0;
      info_in   = '0;
      check_in  = '0;
      end_in    = bad ? 1'b1 : last;
      if (!bad) begin
         if (is_init) begin
            kind_in  = KIND_INIT;
            wide_in  = {p[4], p[5], p[6], p[7], p[8], p[9], p[10], p[11]};
            info_in  = {24'd0, p[14]};
            check_in = {p[15], p[16], p[17], p[18]};
         end else if (is_msg) begin
            kind_in  = KIND_MESSAGE;
            info_in  = {p[0], p[1], p[13], p[14]};
            check_in = {p[15], p[16], p[17], p[18]};
         end else if (is_ds) begin
            kind_in   = KIND_DATA_SET;
            wide_in   = {32'd0, p[0], p[1], p[2], p[3]};
            x_in      = {p[4], p[5], p[6]};
            y_in      = {p[7], p[8], p[9]};
            z_in      = {p[10], p[11], p[12]};
            status_in = {p[13], p[14], p[15], p[16]};
            marker_in = p[17][6:0];
            module_in = p[18][3:0];
            trig_in   = {p[15][7:5], p[16][7:5]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= '0;
         rec_pos_ff   <= '0;
         len_bad_ff   <= 1'b0;
      end else if (accept) begin
         frame_pos_ff <= frame_pos_in;
         rec_pos_ff   <= rec_pos_in;
         len_bad_ff   <= len_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_we) begin
         store_ff[fpos] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         kind_ff   <= kind_in;
         wide_ff   <= wide_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         status_ff <= status_in;
         marker_ff <= marker_in;
         module_ff <= module_in;
         trig_ff   <= trig_in;
         info_ff   <= info_in;
         check_ff  <= check_in;
         end_ff    <= end_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_kind    = kind_ff;
   assign rsp_wide_word     = wide_ff;
   assign rsp_x_coord       = x_ff;
   assign rsp_y_coord       = y_ff;
   assign rsp_z_coord       = z_ff;
   assign rsp_status_word   = status_ff;
   assign rsp_marker_id     = marker_ff;
   assign rsp_module_id     = module_ff;
   assign rsp_trigger_index = trig_ff;
   assign rsp_message_info  = info_ff;
   assign rsp_check_word    = check_ff;
   assign rsp_record_end    = end_ff;

endmodule

>>> rtl/trfd_checker.sv
// ----------------------------------------------------------------------------
// trfd_checker
// Port-level checks for the tracker reply frame decoder, bound to the decoder unit.
// ----------------------------------------------------------------------------
`include "tracker_reply_frame_decoder_unit_assert.svh"

module trfd_checker import trfd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_record_start,
   input logic [LEN_W-1:0]      req_record_length,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_frame_kind,
   input logic [63:0]           rsp_wide_word,
   input logic signed [23:0]    rsp_x_coord,
   input logic signed [23:0]    rsp_y_coord,
   input logic signed [23:0]    rsp_z_coord,
   input logic [31:0]           rsp_status_word,
   input logic [6:0]            rsp_marker_id,
   input logic [3:0]            rsp_module_id,
   input logic [5:0]            rsp_trigger_index,
   input logic [31:0]           rsp_message_info,
   input logic [31:0]           rsp_check_word,
   input logic                  rsp_record_end
);

   logic fields_zero, ds_fields_zero;

   assign ds_fields_zero = (rsp_x_coord == '0) && (rsp_y_coord == '0) &&
                           (rsp_z_coord == '0) && (rsp_status_word == '0) &&
                           (rsp_marker_id == '0) && (rsp_module_id == '0) &&
                           (rsp_trigger_index == '0);
   assign fields_zero    = ds_fields_zero && (rsp_wide_word == '0) &&
                           (rsp_message_info == '0) && (rsp_check_word == '0);

   // a stalled response stays valid and keeps its kind, wide word, check word and end flag
   `TRFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_kind) && $stable(rsp_wide_word) && $stable(rsp_check_word) && $stable(rsp_record_end))

   `TRFD_ASSERT_IMPLY(a_unknown_zero, clock, reset, rsp_valid && (rsp_frame_kind == KIND_UNKNOWN), fields_zero)

   `TRFD_ASSERT_IMPLY(a_non_ds_zero, clock, reset, rsp_valid && (rsp_frame_kind != KIND_DATA_SET), ds_fields_zero)

   // a one-byte record is never frame-aligned: its result is unknown and ends the record
   `TRFD_ASSERT_NEXT(a_short_record, clock, reset, req_valid && req_ready && req_record_start && (req_record_length == LEN_W'(1)), rsp_valid && (rsp_frame_kind == KIND_UNKNOWN) && rsp_record_end)

endmodule

bind tracker_reply_frame_decoder_unit trfd_checker u_trfd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_record_start  (req_record_start),
   .req_record_length (req_record_length),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_frame_kind    (rsp_frame_kind),
   .rsp_wide_word     (rsp_wide_word),
   .rsp_x_coord       (rsp_x_coord),
   .rsp_y_coord       (rsp_y_coord),
   .rsp_z_coord       (rsp_z_coord),
   .rsp_status_word   (rsp_status_word),
   .rsp_marker_id     (rsp_marker_id),
   .rsp_module_id     (rsp_module_id),
   .rsp_trigger_index (rsp_trigger_index),
   .rsp_message_info  (rsp_message_info),
   .rsp_check_word    (rsp_check_word),
   .rsp_record_end    (rsp_record_end)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for tracker_reply_frame_decoder_unit
// Streams record bytes with random gaps into the decoder, predicts every
// decoded frame in step with the accepted requests and compares each result
// field by field while the result side stalls at random.
// ----------------------------------------------------------------------------
module testbench;
   import trfd_pkg::*;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             start;
      logic [LEN_W-1:0] length;
   } rx_request_type;

   typedef struct packed {
      frame_kind_type kind;
      logic [63:0]    wide_word;
      logic [23:0]    x_coord;
      logic [23:0]    y_coord;
      logic [23:0]    z_coord;
      logic [31:0]    status_word;
      logic [6:0]     marker_id;
      logic [3:0]     module_id;
      logic [5:0]     trigger_index;
      logic [31:0]    message_info;
      logic [31:0]    check_word;
      logic           record_end;
   } decoded_frame_type;

   typedef enum int {
      RECIPE_INIT,
      RECIPE_NEAR_INIT,
      RECIPE_ACK,
      RECIPE_ERROR,
      RECIPE_DATA_SET,
      RECIPE_OVERLAP,
      RECIPE_UNKNOWN,
      RECIPE_NOISE
   } frame_recipe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rx_request_type cur_req = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_frame_kind;
   logic [63:0] rsp_wide_word;
   logic signed [23:0] rsp_x_coord;
   logic signed [23:0] rsp_y_coord;
   logic signed [23:0] rsp_z_coord;
   logic [31:0] rsp_status_word;
   logic [6:0]  rsp_marker_id;
   logic [3:0]  rsp_module_id;
   logic [5:0]  rsp_trigger_index;
   logic [31:0] rsp_message_info;
   logic [31:0] rsp_check_word;
   logic        rsp_record_end;

   rx_request_type    pending_bytes[$];
   decoded_frame_type expected_frames[$];
   int unsigned    queued_count = 0;
   int unsigned    mismatches = 0;
   int unsigned    send_gap = 0;
   int unsigned    stall_left = 0;
   logic           req_fire = 1'b0;

   // predictor state
   logic [7:0]  frame_buf [FRAME_BYTES];
   int unsigned frame_fill = 0;
   int unsigned bytes_taken = 0;
   bit          length_rejected = 1'b0;

   tracker_reply_frame_decoder_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (cur_req.rx_byte),
      .req_record_start  (cur_req.start),
      .req_record_length (cur_req.length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_kind    (rsp_frame_kind),
      .rsp_wide_word     (rsp_wide_word),
      .rsp_x_coord       (rsp_x_coord),
      .rsp_y_coord       (rsp_y_coord),
      .rsp_z_coord       (rsp_z_coord),
      .rsp_status_word   (rsp_status_word),
      .rsp_marker_id     (rsp_marker_id),
      .rsp_module_id     (rsp_module_id),
      .rsp_trigger_index (rsp_trigger_index),
      .rsp_message_info  (rsp_message_info),
      .rsp_check_word    (rsp_check_word),
      .rsp_record_end    (rsp_record_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic bit is_text_char(input logic [7:0] c);
      return (c >= PRINT_FIRST) && (c <= PRINT_LAST);
   endfunction

   function automatic decoded_frame_type classify_frame();
      decoded_frame_type r;
      bit             ds_tag_seen;
      r = '0;
      r.kind = KIND_UNKNOWN;
      ds_tag_seen = ((frame_buf[18] & TAG_MASK) == DS_TAG) &&
                    ((frame_buf[17] & MARKER_FLAG) == MARKER_FLAG);
      if (frame_buf[0] == INIT_B0 && frame_buf[1] == INIT_B1 &&
          frame_buf[2] == INIT_B2 && frame_buf[3] == INIT_B3) begin
         r.kind = KIND_INIT;
         r.wide_word = {frame_buf[4], frame_buf[5], frame_buf[6], frame_buf[7],
                        frame_buf[8], frame_buf[9], frame_buf[10], frame_buf[11]};
         r.message_info = {24'h0, frame_buf[14]};
         r.check_word = {frame_buf[15], frame_buf[16], frame_buf[17], frame_buf[18]};
      end else if ((frame_buf[14] == ACK_CODE && is_text_char(frame_buf[0])) ||
                   (!ds_tag_seen && is_text_char(frame_buf[0]) &&
                    is_text_char(frame_buf[1]))) begin
         // acknowledged and error messages share one layout
         r.kind = KIND_MESSAGE;
         r.message_info = {frame_buf[0], frame_buf[1], frame_buf[13], frame_buf[14]};
         r.check_word = {frame_buf[15], frame_buf[16], frame_buf[17], frame_buf[18]};
      end else if (ds_tag_seen) begin
         r.kind = KIND_DATA_SET;
         r.wide_word = {32'h0, frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]};
         r.x_coord = {frame_buf[4], frame_buf[5], frame_buf[6]};
         r.y_coord = {frame_buf[7], frame_buf[8], frame_buf[9]};
         r.z_coord = {frame_buf[10], frame_buf[11], frame_buf[12]};
         r.status_word = {frame_buf[13], frame_buf[14], frame_buf[15], frame_buf[16]};
         r.marker_id = frame_buf[17][6:0];
         r.module_id = frame_buf[18][3:0];
         r.trigger_index = {frame_buf[15][7:5], frame_buf[16][7:5]};
      end
      return r;
   endfunction

   // advances the predictor by one accepted request; 1 when a result is due
   function automatic bit take_byte(input rx_request_type rq, output decoded_frame_type res);
      int unsigned len;
      bit          is_last;
      len = rq.length;
      res = '0;
      res.kind = KIND_UNKNOWN;
      if (rq.start) begin
         bytes_taken = 0;
         frame_fill = 0;
         length_rejected = (len == 0) || (len > MAX_RECORD_BYTES) ||
                           (len % FRAME_BYTES != 0);
      end
      if (bytes_taken >= len)
         return 1'b0;
      is_last = (bytes_taken + 1 == len);
      bytes_taken++;
      if (length_rejected) begin
         res.record_end = 1'b1;
         return is_last;
      end
      frame_buf[frame_fill] = rq.rx_byte;
      if (frame_fill < FRAME_BYTES - 1) begin
         frame_fill++;
         return 1'b0;
      end
      frame_fill = 0;
      res = classify_frame();
      res.record_end = is_last;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // quiet windows keep some stretches free of gaps and stalls
   function automatic int unsigned idle_length();
      int unsigned r;
      if (($time / 10) % 600 < 150)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin : monitor
      decoded_frame_type predicted;
      decoded_frame_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, rsp_frame_kind);
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_kind", want.kind, rsp_frame_kind);
               check_field("wide_word", want.wide_word, rsp_wide_word);
               check_field("x_coord", want.x_coord, $unsigned(rsp_x_coord));
               check_field("y_coord", want.y_coord, $unsigned(rsp_y_coord));
               check_field("z_coord", want.z_coord, $unsigned(rsp_z_coord));
               check_field("status_word", want.status_word, rsp_status_word);
               check_field("marker_id", want.marker_id, rsp_marker_id);
               check_field("module_id", want.module_id, rsp_module_id);
               check_field("trigger_index", want.trigger_index, rsp_trigger_index);
               check_field("message_info", want.message_info, rsp_message_info);
               check_field("check_word", want.check_word, rsp_check_word);
               check_field("record_end", want.record_end, rsp_record_end);
            end
         end
         if (req_valid && req_ready) begin
            if (take_byte(cur_req, predicted))
               expected_frames.insert(expected_frames.size(), predicted);
         end
      end
   end

   // one request per byte; the payload holds until it is taken
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_bytes.size() > 0) begin
            cur_req <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            send_gap = idle_length();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : sink
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 20)
            stall_left = idle_length();
      end
   end

   function automatic logic [7:0] text_byte();
      return 8'($urandom_range(PRINT_FIRST, PRINT_LAST));
   endfunction

   function automatic logic [7:0] binary_byte();
      if ($urandom_range(0, 1))
         return 8'($urandom_range(0, 8'h1F));
      return 8'($urandom_range(8'h7F, 8'hFF));
   endfunction

   function automatic logic [FRAME_BYTES-1:0][7:0] build_frame(input frame_recipe_type recipe);
      logic [FRAME_BYTES-1:0][7:0] fb;
      for (int i = 0; i < FRAME_BYTES; i++)
         fb[i] = 8'($urandom);
      case (recipe)
         RECIPE_INIT: begin
            fb[0] = INIT_B0;
            fb[1] = INIT_B1;
            fb[2] = INIT_B2;
            fb[3] = INIT_B3;
         end
         RECIPE_NEAR_INIT: begin
            fb[0] = INIT_B0;
            fb[1] = INIT_B1;
            fb[2] = INIT_B2;
            fb[3] = INIT_B3 ^ (8'h01 << $urandom_range(0, 7));
         end
         RECIPE_ACK: begin
            fb[0] = text_byte();
            fb[14] = ACK_CODE;
         end
         RECIPE_ERROR: begin
            fb[0] = text_byte();
            fb[1] = text_byte();
         end
         RECIPE_DATA_SET: begin
            fb[18][7:4] = DS_TAG[7:4];
            fb[17][7] = 1'b1;
            if ($urandom_range(0, 3) != 0)
               fb[0] = binary_byte();
         end
         RECIPE_OVERLAP: begin
            // text header and data set tag together: ack code decides
            fb[0] = text_byte();
            fb[1] = text_byte();
            fb[18][7:4] = DS_TAG[7:4];
            fb[17][7] = 1'b1;
            if ($urandom_range(0, 1))
               fb[14] = ACK_CODE;
         end
         RECIPE_UNKNOWN: begin
            fb[0] = binary_byte();
            fb[17][7] = 1'b0;
         end
         default: ;
      endcase
      return fb;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic s, input int unsigned len);
      rx_request_type rq;
      rq.rx_byte = b;
      rq.start = s;
      rq.length = LEN_W'(len);
      pending_bytes.insert(pending_bytes.size(), rq);
      queued_count++;
   endtask

   function automatic frame_recipe_type any_recipe();
      return frame_recipe_type'($urandom_range(0, RECIPE_NOISE));
   endfunction

   initial begin : stimulus
      logic [FRAME_BYTES-1:0][7:0] fb;
      int unsigned len;
      int unsigned frames;
      int unsigned cut;
      int unsigned sent;
      int unsigned pick;

      // data set with coordinate extremes, taken as a record open since reset
      fb = {8'hEF, 8'hFF, 8'h01, 8'hA0, 8'hE0, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'h7F, 8'h00, 8'h00, 8'h80, 8'h01, 8'h00, 8'h00, 8'h80};
      for (int i = 0; i < FRAME_BYTES; i++)
         queue_byte(fb[i], 1'b0, FRAME_BYTES);
      queue_byte(8'h00, 1'b1, 1);                      // bad length, one byte
      queue_byte(8'h55, 1'b0, 1);                      // past the end
      queue_byte(8'hFF, 1'b1, 0);                      // zero length
      queue_byte(8'hAA, 1'b1, (1 << LEN_W) - 1);       // above the limit
      queue_byte(8'h33, 1'b0, 2);                      // length shrinks to end it

      while (queued_count < 525) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // well-formed record, now and then abandoned early
            frames = $urandom_range(1, 4);
            len = frames * FRAME_BYTES;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
            sent = 0;
            for (int f = 0; f < frames; f++) begin
               fb = build_frame(any_recipe());
               for (int i = 0; i < FRAME_BYTES; i++) begin
                  if (sent < cut)
                     queue_byte(fb[i], sent == 0, len);
                  sent++;
               end
            end
         end else if (pick < 77) begin
            len = $urandom_range(1, 45);
            if (len % FRAME_BYTES == 0)
               len++;
            for (int i = 0; i < len; i++)
               queue_byte(8'($urandom), i == 0, len);
         end else if (pick < 85) begin
            // long record cut short by the next start
            case ($urandom_range(0, 2))
               0: len = 215 * FRAME_BYTES;
               1: len = MAX_RECORD_BYTES;
               default: len = $urandom_range(MAX_RECORD_BYTES + 1, (1 << LEN_W) - 1);
            endcase
            cut = $urandom_range(1, 45);
            for (int i = 0; i < cut; i++) begin
               if (i % FRAME_BYTES == 0)
                  fb = build_frame(any_recipe());
               queue_byte(fb[i % FRAME_BYTES], i == 0, len);
            end
         end else if (pick < 91) begin
            fb = build_frame(any_recipe());
            for (int i = 0; i < FRAME_BYTES; i++)
               queue_byte(fb[i], i == 0, FRAME_BYTES);
            repeat ($urandom_range(1, 3))
               queue_byte(8'($urandom), 1'b0, FRAME_BYTES);
         end else if (pick < 96) begin
            // length moves partway through the record
            len = FRAME_BYTES * $urandom_range(1, 3);
            cut = $urandom_range(1, 30);
            for (int i = 0; i < 2 * FRAME_BYTES; i++) begin
               if (i == cut)
                  len = FRAME_BYTES * $urandom_range(1, 3) + $urandom_range(0, 1);
               if (i % FRAME_BYTES == 0)
                  fb = build_frame(any_recipe());
               queue_byte(fb[i % FRAME_BYTES], i == 0, len);
            end
         end else begin
            repeat ($urandom_range(1, 20))
               queue_byte(8'($urandom), $urandom_range(0, 9) == 0,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, (1 << LEN_W) - 1));
         end
      end
   end

   initial begin : finish_run
      wait (!reset);
      while (pending_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/trfd_pkg.sv
rtl/tracker_reply_frame_decoder_unit.sv
rtl/trfd_checker.sv
verif/testbench.sv
